// ===== rtl/pwm_input_duty_capture_core_assert.svh =====
// assertion macros shared by the checker
`ifndef PWM_INPUT_DUTY_CAPTURE_CORE_ASSERT_SVH
`define PWM_INPUT_DUTY_CAPTURE_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define PIDC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pidc assertion failed");

// next-cycle implication, disabled while in reset
`define PIDC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pidc assertion failed");

`endif

// ===== rtl/pidc_pkg.sv =====
package pidc_pkg;

  // widths fixed by the interface
  localparam int OUT_W      = 16;
  localparam int REG_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int DUTY_BITS  = 16;
  localparam int STEP_W     = $clog2(DUTY_BITS);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRESCALE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELOAD   = 1'd1;

  localparam logic [REG_W-1:0] PRESCALE_RST = 16'h0000;
  localparam logic [REG_W-1:0] RELOAD_RST   = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_PUSH
  } pidc_state_t;

  // controller to datapath
  typedef struct packed {
    logic step;      // apply one tick to counters and captures
    logic div_load;  // seed divider from captures
    logic div_run;   // one quotient bit
    logic out_load;  // move result into output word
  } pidc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;  // current divider step is the final one
  } pidc_status_t;

endpackage

// ===== rtl/pidc_datapath.sv =====
module pidc_datapath #(
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pidc_pkg::pidc_cmd_t           cmd,
  output pidc_pkg::pidc_status_t        status,
  input  logic                          pin_level,
  input  logic                          cfg_wr_en,
  input  logic [pidc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pidc_pkg::REG_W-1:0]    cfg_data,
  output logic [pidc_pkg::OUT_W-1:0]    period_count,
  output logic [pidc_pkg::OUT_W-1:0]    width_count,
  output logic [pidc_pkg::OUT_W-1:0]    duty_fraction,
  output logic                          period_seen
);
  import pidc_pkg::*;

  localparam int DW = COUNT_BITS + 1;

  logic [REG_W-1:0]      prescale_div_r, prescale_div_nxt;
  logic [REG_W-1:0]      reload_r, reload_nxt;
  logic [REG_W-1:0]      prescale_cnt_r, prescale_cnt_nxt;
  logic [COUNT_BITS-1:0] main_cnt_r, main_cnt_nxt;
  logic                  prev_level_r, prev_level_nxt;
  logic [COUNT_BITS-1:0] period_cap_r, period_cap_nxt;
  logic [COUNT_BITS-1:0] width_cap_r, width_cap_nxt;
  logic                  seen_r, seen_nxt;

  logic [DW-1:0]         rem_r, rem_nxt;
  logic [DW-1:0]         den_r, den_nxt;
  logic [DUTY_BITS-1:0]  quo_r, quo_nxt;
  logic                  sat_r, sat_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;

  logic [OUT_W-1:0]      out_period_r, out_period_nxt;
  logic [OUT_W-1:0]      out_width_r, out_width_nxt;
  logic [OUT_W-1:0]      out_duty_r, out_duty_nxt;
  logic                  out_seen_r, out_seen_nxt;

  logic                  rising, falling;
  logic [COUNT_BITS-1:0] reload_cnt;
  logic [DW:0]           rem_sh;
  logic [DW:0]           den_ext;

  // config registers
  always_comb begin
    prescale_div_nxt = prescale_div_r;
    reload_nxt       = reload_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_PRESCALE: prescale_div_nxt = cfg_data;
        REG_RELOAD:   reload_nxt       = cfg_data;
        default: ;
      endcase
    end
  end

  // counters and captures
  assign rising     = pin_level & ~prev_level_r;
  assign falling    = ~pin_level & prev_level_r;
  assign reload_cnt = COUNT_BITS'(reload_r);

  always_comb begin
    prescale_cnt_nxt = prescale_cnt_r;
    main_cnt_nxt     = main_cnt_r;
    prev_level_nxt   = prev_level_r;
    period_cap_nxt   = period_cap_r;
    width_cap_nxt    = width_cap_r;
    seen_nxt         = seen_r;
    if (cmd.step) begin
      prev_level_nxt = pin_level;
      if (rising) begin
        period_cap_nxt   = main_cnt_r;
        main_cnt_nxt     = '0;
        prescale_cnt_nxt = '0;
        seen_nxt         = 1'b1;
      end else begin
        if (falling) begin
          width_cap_nxt = main_cnt_r;
        end
        if (prescale_cnt_r >= prescale_div_r) begin
          prescale_cnt_nxt = '0;
          if (main_cnt_r >= reload_cnt) begin
            main_cnt_nxt = '0;
          end else begin
            main_cnt_nxt = main_cnt_r + COUNT_BITS'(1);
          end
        end else begin
          prescale_cnt_nxt = prescale_cnt_r + REG_W'(1);
        end
      end
    end
  end

  // restoring divider, one quotient bit per step
  assign rem_sh  = {rem_r, 1'b0};
  assign den_ext = {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    sat_nxt  = sat_r;
    step_nxt = step_r;
    if (cmd.div_load) begin
      rem_nxt  = DW'(width_cap_r) + DW'(1);
      den_nxt  = DW'(period_cap_r) + DW'(1);
      quo_nxt  = '0;
      sat_nxt  = (width_cap_r >= period_cap_r);
      step_nxt = '0;
    end else if (cmd.div_run) begin
      step_nxt = step_r + STEP_W'(1);
      if (rem_sh >= den_ext) begin
        rem_nxt = DW'(rem_sh - den_ext);
        quo_nxt = {quo_r[DUTY_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = DW'(rem_sh);
        quo_nxt = {quo_r[DUTY_BITS-2:0], 1'b0};
      end
    end
  end

  assign status.div_last = (step_r == STEP_W'(DUTY_BITS - 1));

  // result word
  always_comb begin
    out_period_nxt = out_period_r;
    out_width_nxt  = out_width_r;
    out_duty_nxt   = out_duty_r;
    out_seen_nxt   = out_seen_r;
    if (cmd.out_load) begin
      out_period_nxt = OUT_W'(period_cap_r);
      out_width_nxt  = OUT_W'(width_cap_r);
      out_duty_nxt   = sat_r ? '1 : OUT_W'(quo_r);
      out_seen_nxt   = seen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_div_r <= PRESCALE_RST;
      reload_r       <= RELOAD_RST;
      prescale_cnt_r <= '0;
      main_cnt_r     <= '0;
      prev_level_r   <= 1'b0;
      period_cap_r   <= '0;
      width_cap_r    <= '0;
      seen_r         <= 1'b0;
      step_r         <= '0;
      out_seen_r     <= 1'b0;
    end else begin
      prescale_div_r <= prescale_div_nxt;
      reload_r       <= reload_nxt;
      prescale_cnt_r <= prescale_cnt_nxt;
      main_cnt_r     <= main_cnt_nxt;
      prev_level_r   <= prev_level_nxt;
      period_cap_r   <= period_cap_nxt;
      width_cap_r    <= width_cap_nxt;
      seen_r         <= seen_nxt;
      step_r         <= step_nxt;
      out_seen_r     <= out_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r        <= rem_nxt;
    den_r        <= den_nxt;
    quo_r        <= quo_nxt;
    sat_r        <= sat_nxt;
    out_period_r <= out_period_nxt;
    out_width_r  <= out_width_nxt;
    out_duty_r   <= out_duty_nxt;
  end

  assign period_count  = out_period_r;
  assign width_count   = out_width_r;
  assign duty_fraction = out_duty_r;
  assign period_seen   = out_seen_r;

endmodule

// ===== rtl/pidc_ctrl.sv =====
module pidc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  output pidc_pkg::pidc_cmd_t    cmd,
  input  pidc_pkg::pidc_status_t status
);
  import pidc_pkg::*;

  pidc_state_t state_r, state_nxt;
  logic        out_full_r, out_full_nxt;
  logic        slot_free;

  // output word can take a new result this cycle
  assign slot_free = ~out_full_r | ~out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV:  if (status.div_last) state_nxt = ST_PUSH;
      ST_PUSH: if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_stall     = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.step = in_valid;
      end
      ST_LOAD: cmd.div_load = 1'b1;
      ST_DIV:  cmd.div_run  = 1'b1;
      ST_PUSH: cmd.out_load = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_full_nxt = 1'b1;
    end else begin
      out_full_nxt = out_full_r & out_stall;
    end
  end

  assign out_valid = out_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      out_full_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_full_r <= out_full_nxt;
    end
  end

endmodule

// ===== rtl/pwm_input_duty_capture_core.sv =====
// PWM input capture timer. Each accepted input word is one timer tick carrying the sampled
// pin level. A 16-bit prescaler divides ticks by prescale_divider+1 and advances an up-counter
// that wraps after reload_value. A rising edge captures the counter as the period and clears
// counter and prescaler; a falling edge captures the counter as the high width. Every input
// word yields exactly one output word with both captures, the duty (width+1)/(period+1) as
// unsigned Q0.16 saturated at 0xFFFF, and a flag set once a period has been captured.
// Sequence: input words are handled one at a time; the tick is applied, the divider is seeded,
// the restoring divider produces one duty bit per cycle, and the result is handed to the output
// register. The output register holds a finished word while the next tick is taken and
// divided, so the input side is held while a word is being worked on and, beyond that, only
// if a result is still waiting when the next one is ready. Register writes take effect at once
// and are meant to happen while the block is idle.
module pwm_input_duty_capture_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input word channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_pin_level,
  // result word channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pidc_pkg::OUT_W-1:0]    out_period_count,
  output logic [pidc_pkg::OUT_W-1:0]    out_width_count,
  output logic [pidc_pkg::OUT_W-1:0]    out_duty_fraction,
  output logic                          out_period_seen,
  // register write port: index 0 prescale divider, index 1 reload value
  input  logic                          cfg_wr_en,
  input  logic [pidc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pidc_pkg::REG_W-1:0]    cfg_data
);
  import pidc_pkg::*;

  pidc_cmd_t    cmd;
  pidc_status_t status;

  // sequencer: tick, divider seed, 16 divide steps, result hand-off
  pidc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // counters, captures, duty divider and output word
  pidc_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .pin_level     (in_pin_level),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .period_count  (out_period_count),
    .width_count   (out_width_count),
    .duty_fraction (out_duty_fraction),
    .period_seen   (out_period_seen)
  );

endmodule

// ===== rtl/pidc_checker.sv =====
`include "pwm_input_duty_capture_core_assert.svh"

module pidc_checker #(
  parameter int COUNT_BITS = 16
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [pidc_pkg::OUT_W-1:0] out_period_count,
  input logic [pidc_pkg::OUT_W-1:0] out_width_count,
  input logic [pidc_pkg::OUT_W-1:0] out_duty_fraction,
  input logic                       out_period_seen
);
  import pidc_pkg::*;

  // a held result keeps valid and its duty
  `PIDC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_duty_fraction))

  // one tick at a time: busy right after taking a word
  `PIDC_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

  // period flag never drops once set
  `PIDC_ASSERT_NXT(a_seen_sticky, clk, rst_n, out_period_seen, out_period_seen)

  // width at or above period saturates the duty
  `PIDC_ASSERT_IMP(a_duty_sat, clk, rst_n, out_valid && (COUNT_BITS <= OUT_W) && (out_width_count >= out_period_count), out_duty_fraction == 16'hFFFF)

endmodule

bind pwm_input_duty_capture_core pidc_checker #(.COUNT_BITS(COUNT_BITS)) u_pidc_checker (.*);
